[sv/tcphm_pkg.sv]
// Shared types, constants and helpers for the TCP header match and checksum check.
package tcphm_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned IDX_W     = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_PORT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_PORT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAGS    = 3'd4;

   // Register reset values
   localparam logic [15:0] RST_SRC_PORT = 16'd1337;
   localparam logic [15:0] RST_DST_PORT = 16'd7331;
   localparam logic [31:0] RST_SEQ      = 32'd321342;
   localparam logic [31:0] RST_ACK      = 32'd81321;
   localparam logic [7:0]  RST_FLAGS    = 8'd4;

   // Frame byte offsets
   localparam logic [IDX_W-1:0] OFF_PROTO     = 6'd23;
   localparam logic [IDX_W-1:0] OFF_SRC_ADDR  = 6'd26;
   localparam logic [IDX_W-1:0] OFF_SRC_ADDR_END = 6'd29;
   localparam logic [IDX_W-1:0] OFF_SPORT     = 6'd34;
   localparam logic [IDX_W-1:0] OFF_SPORT_END = 6'd35;
   localparam logic [IDX_W-1:0] OFF_DPORT     = 6'd36;
   localparam logic [IDX_W-1:0] OFF_DPORT_END = 6'd37;
   localparam logic [IDX_W-1:0] OFF_SEQ       = 6'd38;
   localparam logic [IDX_W-1:0] OFF_SEQ_END   = 6'd41;
   localparam logic [IDX_W-1:0] OFF_ACK       = 6'd42;
   localparam logic [IDX_W-1:0] OFF_ACK_END   = 6'd45;
   localparam logic [IDX_W-1:0] OFF_FLAGS     = 6'd47;
   localparam logic [IDX_W-1:0] OFF_CSUM_HI   = 6'd50;
   localparam logic [IDX_W-1:0] OFF_CSUM_LO   = 6'd51;
   localparam logic [IDX_W-1:0] OFF_LAST      = 6'd53;
   localparam logic [IDX_W-1:0] FRAME_LEN     = 6'd54;
   localparam logic [IDX_W-1:0] IDX_MAX       = 6'd63;

   localparam logic [7:0]  PROTO_TCP  = 8'h06;
   // Pseudo-header protocol plus TCP length
   localparam logic [15:0] PSEUDO_ADD = 16'd26;

   typedef struct packed {
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  flags;
   } cfg_type;

   typedef struct packed {
      logic        length_ok;
      logic        header_match;
      logic        checksum_good;
      logic [31:0] source_address;
   } result_type;

   // Ones' complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

endpackage

[sv/tcphm_csr.sv]
// Match registers written through the csr port.
module tcphm_csr import tcphm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [CSR_DAT_W-1:0] wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SRC_PORT: cfg_in.src_port = wr_data[15:0];
            CSR_DST_PORT: cfg_in.dst_port = wr_data[15:0];
            CSR_SEQ:      cfg_in.seq      = wr_data;
            CSR_ACK:      cfg_in.ack      = wr_data;
            CSR_FLAGS:    cfg_in.flags    = wr_data[7:0];
            default:      cfg_in = cfg_ff; // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{src_port: RST_SRC_PORT, dst_port: RST_DST_PORT, seq: RST_SEQ,
                     ack: RST_ACK, flags: RST_FLAGS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/tcphm_frame.sv]
// Per-byte frame tracking: field compare, checksum sum and end-of-frame verdict.
module tcphm_frame import tcphm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [BYTE_W-1:0] frame_byte,
   input  logic              last_of_frame,
   input  cfg_type           cfg,
   output result_type        result
);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [15:0]      sum_acc_ff, sum_acc_in;
   logic [7:0]       held_high_byte_ff, held_high_byte_in;
   logic             fields_ok_ff, fields_ok_in;
   logic [31:0]      src_addr_ff, src_addr_in;
   logic [15:0]      rx_checksum_ff, rx_checksum_in;

   logic [IDX_W-1:0] rel;
   logic [7:0]       expect_byte;
   logic             check;
   logic [7:0]       sum_byte;
   logic [15:0]      sum_upd;
   logic [15:0]      total;
   logic             len_ok;

   always_comb begin
      rel         = '0;
      check       = 1'b1;
      expect_byte = '0;
      unique case (byte_index_ff) inside
         OFF_PROTO: expect_byte = PROTO_TCP;
         [OFF_SPORT:OFF_SPORT_END]: begin
            expect_byte = byte_index_ff[0] ? cfg.src_port[7:0] : cfg.src_port[15:8];
         end
         [OFF_DPORT:OFF_DPORT_END]: begin
            expect_byte = byte_index_ff[0] ? cfg.dst_port[7:0] : cfg.dst_port[15:8];
         end
         [OFF_SEQ:OFF_SEQ_END]: begin
            rel         = byte_index_ff - OFF_SEQ;
            expect_byte = cfg.seq[8*(3-rel[1:0]) +: 8];
         end
         [OFF_ACK:OFF_ACK_END]: begin
            rel         = byte_index_ff - OFF_ACK;
            expect_byte = cfg.ack[8*(3-rel[1:0]) +: 8];
         end
         OFF_FLAGS: expect_byte = cfg.flags;
         default:   check = 1'b0;
      endcase
   end

   always_comb begin
      fields_ok_in      = fields_ok_ff;
      src_addr_in       = src_addr_ff;
      rx_checksum_in    = rx_checksum_ff;
      held_high_byte_in = held_high_byte_ff;
      sum_acc_in        = sum_acc_ff;
      sum_byte          = frame_byte;
      sum_upd           = ones_add(sum_acc_ff, {held_high_byte_ff, sum_byte});

      if (check && (frame_byte != expect_byte)) begin
         fields_ok_in = 1'b0;
      end
      if (byte_index_ff >= OFF_SRC_ADDR && byte_index_ff <= OFF_SRC_ADDR_END) begin
         src_addr_in = {src_addr_ff[23:0], frame_byte};
      end
      if (byte_index_ff == OFF_CSUM_HI || byte_index_ff == OFF_CSUM_LO) begin
         rx_checksum_in = {rx_checksum_ff[7:0], frame_byte};
         sum_byte       = '0; // checksum field counts as zero
         sum_upd        = ones_add(sum_acc_ff, {held_high_byte_ff, sum_byte});
      end
      if (byte_index_ff >= OFF_SRC_ADDR && byte_index_ff < FRAME_LEN) begin
         if (!byte_index_ff[0]) begin
            held_high_byte_in = sum_byte;
         end else begin
            sum_acc_in        = sum_upd;
            held_high_byte_in = '0;
         end
      end

      byte_index_in = (byte_index_ff != IDX_MAX) ? byte_index_ff + 6'd1 : byte_index_ff;

      // Verdict uses this byte's updates
      len_ok                = (byte_index_ff == OFF_LAST);
      total                 = ones_add(sum_acc_in, PSEUDO_ADD);
      result.length_ok      = len_ok;
      result.header_match   = len_ok && fields_ok_in;
      result.checksum_good  = len_ok && ((~total) == rx_checksum_in);
      result.source_address = len_ok ? src_addr_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_of_frame)) begin
         byte_index_ff     <= '0;
         sum_acc_ff        <= '0;
         held_high_byte_ff <= '0;
         fields_ok_ff      <= 1'b1;
         src_addr_ff       <= '0;
         rx_checksum_ff    <= '0;
      end else if (take) begin
         byte_index_ff     <= byte_index_in;
         sum_acc_ff        <= sum_acc_in;
         held_high_byte_ff <= held_high_byte_in;
         fields_ok_ff      <= fields_ok_in;
         src_addr_ff       <= src_addr_in;
         rx_checksum_ff    <= rx_checksum_in;
      end
   end

endmodule

[sv/tcp_header_match_checksum_check.sv]
// Top level: input register, frame checker and result register.
//
// Streams an Ethernet frame one byte per req beat, with req_last_of_frame on
// the final byte, and returns one rsp beat per frame. A frame passes the
// length check only at exactly 54 bytes; header_match additionally needs IP
// protocol 6 and TCP ports, sequence, acknowledgement and flags equal to the
// csr registers (index 0..4: src port, dst port, seq, ack, flags). The TCP
// checksum is summed over the pseudo-header and TCP header as bytes stream
// by, so the verdict is ready on the last byte. One byte is accepted every
// cycle while req_stall is low; the path is one input register and one result
// register, and the last byte of a frame passes both before rsp_valid rises.
// req_stall rises only when a last byte waits behind an undelivered result
// that rsp_stall holds.
// Write csr registers only between frames; csr_ready is always high.
module tcp_header_match_checksum_check import tcphm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_frame_byte,
   input  logic                 req_last_of_frame,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_length_ok,
   output logic                 rsp_header_match,
   output logic                 rsp_checksum_good,
   output logic [31:0]          rsp_source_address,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type    cfg;
   result_type result;

   // input register
   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // result register
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff;

   logic advance;
   logic rsp_free;
   logic req_take;

   assign csr_ready = 1'b1;

   tcphm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Result slot is free when empty or being taken this cycle
   assign rsp_free = !rsp_vld_ff || !rsp_stall;
   // A non-last beat never makes a result, so it always advances
   assign advance  = in_vld_ff && (!in_last_ff || rsp_free);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   tcphm_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .take          (advance),
      .frame_byte    (in_byte_ff),
      .last_of_frame (in_last_ff),
      .cfg           (cfg),
      .result        (result)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance && in_last_ff) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload: load the input beat on accept, the verdict on a last beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_frame_byte;
         in_last_ff <= req_last_of_frame;
      end
      if (advance && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_length_ok      = rsp_ff.length_ok;
   assign rsp_header_match   = rsp_ff.header_match;
   assign rsp_checksum_good  = rsp_ff.checksum_good;
   assign rsp_source_address = rsp_ff.source_address;

   // Both registers empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_vld_ff))
      else $error("pipeline not empty after reset");

   // Stall only with a beat held in the input register
   a_stall_has_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && in_last_ff && rsp_vld_ff))
      else $error("request stalled without a pending last beat");

   // Header match implies correct length
   a_match_needs_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_header_match || rsp_length_ok))
      else $error("header match on wrong-length frame");

   // Wrong length reports zero checksum verdict and address
   a_bad_len_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_length_ok) |-> (!rsp_checksum_good && rsp_source_address == '0))
      else $error("wrong-length frame reports checksum or address");

   // A result held under stall blocks the next last beat from overwriting it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(advance && in_last_ff))
      else $error("pending result overwritten");

endmodule

[tb/testbench.sv]
// Testbench for the TCP header match and checksum check: stimulus, prediction and checking.
module testbench;
   import tcphm_pkg::*;

   // Kinds of header damage a shaped frame can carry
   typedef enum int {
      FLAW_NONE,
      FLAW_PROTO,
      FLAW_SPORT,
      FLAW_DPORT,
      FLAW_SEQ,
      FLAW_ACK,
      FLAW_FLAGS
   } flaw_type;

   // Predicts one verdict per frame and checks each rsp beat against the oldest one
   class verdict_board_type;
      logic [15:0] want_sport;
      logic [15:0] want_dport;
      logic [31:0] want_seq;
      logic [31:0] want_ack;
      logic [7:0]  want_flags;
      logic [5:0]  pos;
      logic [15:0] sum;
      logic [7:0]  high_byte;
      bit          fields_ok;
      logic [31:0] src_addr;
      logic [15:0] rx_csum;
      result_type  verdicts_due[$];
      int          mismatches;

      function new();
         want_sport = RST_SRC_PORT;
         want_dport = RST_DST_PORT;
         want_seq   = RST_SEQ;
         want_ack   = RST_ACK;
         want_flags = RST_FLAGS;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos       = '0;
         sum       = '0;
         high_byte = '0;
         fields_ok = 1'b1;
         src_addr  = '0;
         rx_csum   = '0;
      endfunction

      function logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
         logic [16:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[15:0] + {15'd0, s[16]};
      endfunction

      function void program_register(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_SRC_PORT: want_sport = data[15:0];
            CSR_DST_PORT: want_dport = data[15:0];
            CSR_SEQ:      want_seq   = data;
            CSR_ACK:      want_ack   = data;
            CSR_FLAGS:    want_flags = data[7:0];
            default: ;
         endcase
      endfunction

      function void take_byte(input logic [7:0] b, input logic last);
         logic [7:0]  want;
         logic [7:0]  low_byte;
         logic [15:0] csum;
         bit          compare;
         result_type  v;
         if (pos < FRAME_LEN) begin
            compare = 1'b1;
            want = '0;
            if (pos == OFF_PROTO) want = PROTO_TCP;
            else if (pos >= OFF_SPORT && pos <= OFF_SPORT_END)
               want = 8'(want_sport >> (8 * (OFF_SPORT_END - pos)));
            else if (pos >= OFF_DPORT && pos <= OFF_DPORT_END)
               want = 8'(want_dport >> (8 * (OFF_DPORT_END - pos)));
            else if (pos >= OFF_SEQ && pos <= OFF_SEQ_END)
               want = 8'(want_seq >> (8 * (OFF_SEQ_END - pos)));
            else if (pos >= OFF_ACK && pos <= OFF_ACK_END)
               want = 8'(want_ack >> (8 * (OFF_ACK_END - pos)));
            else if (pos == OFF_FLAGS) want = want_flags;
            else compare = 1'b0;
            if (compare && b != want) fields_ok = 1'b0;

            if (pos >= OFF_SRC_ADDR && pos <= OFF_SRC_ADDR_END) src_addr = {src_addr[23:0], b};
            if (pos == OFF_CSUM_HI || pos == OFF_CSUM_LO) rx_csum = {rx_csum[7:0], b};

            if (pos >= OFF_SRC_ADDR) begin
               low_byte = (pos == OFF_CSUM_HI || pos == OFF_CSUM_LO) ? 8'h00 : b;
               if (!pos[0]) begin
                  high_byte = low_byte;
               end else begin
                  sum = fold_add(sum, {high_byte, low_byte});
                  high_byte = '0;
               end
            end
         end

         if (!last) begin
            if (pos != IDX_MAX) pos++;
            return;
         end

         csum = ~fold_add(sum, PSEUDO_ADD);
         v.length_ok      = (pos == OFF_LAST);
         v.header_match   = v.length_ok && fields_ok;
         v.checksum_good  = v.length_ok && (csum == rx_csum);
         v.source_address = v.length_ok ? src_addr : '0;
         verdicts_due.push_back(v);
         clear_frame();
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_verdict(input result_type got);
         result_type want;
         if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("result %h with no frame outstanding", got));
            return;
         end
         want = verdicts_due.pop_front();
         if (got.length_ok !== want.length_ok)
            report_mismatch($sformatf("length_ok %b, want %b", got.length_ok, want.length_ok));
         if (got.header_match !== want.header_match)
            report_mismatch($sformatf("header_match %b, want %b",
                                      got.header_match, want.header_match));
         if (got.checksum_good !== want.checksum_good)
            report_mismatch($sformatf("checksum_good %b, want %b",
                                      got.checksum_good, want.checksum_good));
         if (got.source_address !== want.source_address)
            report_mismatch($sformatf("source_address %h, want %h",
                                      got.source_address, want.source_address));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_frame_byte = '0;
   logic                 req_last_of_frame = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_length_ok;
   logic                 rsp_header_match;
   logic                 rsp_checksum_good;
   logic [31:0]          rsp_source_address;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   verdict_board_type board;
   // Settings the frame builder shapes headers after; mirrors what was last written
   cfg_type live_cfg = '{src_port: RST_SRC_PORT, dst_port: RST_DST_PORT, seq: RST_SEQ,
                         ack: RST_ACK, flags: RST_FLAGS};
   // Raised by the stimulus to ask the receiver for one long hold-off
   bit squeeze_req = 1'b0;

   tcp_header_match_checksum_check uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_byte     (req_frame_byte),
      .req_last_of_frame  (req_last_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_length_ok      (rsp_length_ok),
      .rsp_header_match   (rsp_header_match),
      .rsp_checksum_good  (rsp_checksum_good),
      .rsp_source_address (rsp_source_address),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run away guard: far beyond the slowest correct run
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   // Offer one byte after an idle gap; enter and leave on a falling edge.
   // Valid stays high on return so back-to-back beats never drop it.
   task automatic push_byte(input logic [7:0] b, input logic last, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_frame_byte    <= b;
      req_last_of_frame <= last;
      // Hold the beat until the block takes it
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_byte(b, last);
      @(negedge clock);
   endtask

   // Write one register; the caller drops csr_valid after its last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.program_register(idx, data);
      @(negedge clock);
   endtask

   // Program every register, with junk in the unused upper bits of the narrow ones,
   // and finish with a write to an index past the last register, which must do nothing.
   task automatic load_settings(input cfg_type s);
      logic [31:0] junk;
      junk = $urandom();
      write_reg(CSR_SRC_PORT, {junk[31:16], s.src_port});
      write_reg(CSR_DST_PORT, {junk[15:0], s.dst_port});
      write_reg(CSR_SEQ, s.seq);
      write_reg(CSR_ACK, s.ack);
      write_reg(CSR_FLAGS, {junk[23:0], s.flags});
      write_reg(CSR_FLAGS + 3'($urandom_range(1, 3)), $urandom());
      csr_valid <= 1'b0;
      live_cfg = s;
   endtask

   // Drop valid, wait for every verdict to come back, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Build and stream one frame. A shaped frame of at least 54 bytes carries protocol 6,
   // the live ports, seq, ack and flags, an optional single-bit header flaw, and a
   // checksum that is correct unless bad_csum asks for one bit to be flipped in it.
   task automatic send_frame(input int len, input bit shaped, input flaw_type flaw,
                             input bit bad_csum, input bit hurry);
      logic [7:0]  frame_buf [0:79];
      logic [16:0] acc;
      logic [15:0] word;
      int          lo;
      int          hi;
      int          k;
      bit          steady;
      steady = hurry || ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) frame_buf[k] = 8'($urandom());

      if (shaped && len >= FRAME_LEN) begin
         frame_buf[OFF_PROTO] = PROTO_TCP;
         for (k = 0; k < 2; k++) begin
            frame_buf[OFF_SPORT + k] = live_cfg.src_port[15 - 8 * k -: 8];
            frame_buf[OFF_DPORT + k] = live_cfg.dst_port[15 - 8 * k -: 8];
         end
         for (k = 0; k < 4; k++) begin
            frame_buf[OFF_SEQ + k] = live_cfg.seq[31 - 8 * k -: 8];
            frame_buf[OFF_ACK + k] = live_cfg.ack[31 - 8 * k -: 8];
         end
         frame_buf[OFF_FLAGS] = live_cfg.flags;

         // Damage before the checksum so the checksum still agrees with the header
         lo = 0;
         hi = 0;
         case (flaw)
            FLAW_PROTO: begin lo = OFF_PROTO; hi = OFF_PROTO; end
            FLAW_SPORT: begin lo = OFF_SPORT; hi = OFF_SPORT_END; end
            FLAW_DPORT: begin lo = OFF_DPORT; hi = OFF_DPORT_END; end
            FLAW_SEQ:   begin lo = OFF_SEQ;   hi = OFF_SEQ_END; end
            FLAW_ACK:   begin lo = OFF_ACK;   hi = OFF_ACK_END; end
            FLAW_FLAGS: begin lo = OFF_FLAGS; hi = OFF_FLAGS; end
            default: ;
         endcase
         if (flaw != FLAW_NONE) begin
            k = $urandom_range(lo, hi);
            frame_buf[k] = frame_buf[k] ^ 8'(1 << $urandom_range(0, 7));
         end

         // Sum pseudo-header and TCP header with the checksum field as zero
         acc = {1'b0, PSEUDO_ADD};
         for (k = OFF_SRC_ADDR; k < FRAME_LEN; k += 2) begin
            word = (k == OFF_CSUM_HI) ? 16'h0000 : {frame_buf[k], frame_buf[k + 1]};
            acc  = {1'b0, acc[15:0]} + {1'b0, word};
            acc  = {1'b0, acc[15:0]} + {16'h0000, acc[16]};
         end
         word = ~acc[15:0];
         if (bad_csum) word = word ^ 16'(1 << $urandom_range(0, 15));
         frame_buf[OFF_CSUM_HI] = word[15:8];
         frame_buf[OFF_CSUM_LO] = word[7:0];
      end

      for (k = 0; k < len; k++)
         push_byte(frame_buf[k], k == len - 1, steady ? 0 : $urandom_range(0, 3));
   endtask

   // Well-formed 54-byte segments with random content 30% of the time, the rest broken or noise
   task automatic random_frame();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         send_frame(FRAME_LEN, 1'b1, FLAW_NONE, 1'b0, 1'b0);
      else if (pick < 50)
         send_frame(FRAME_LEN, 1'b1, flaw_type'($urandom_range(FLAW_PROTO, FLAW_FLAGS)),
                    $urandom_range(0, 1) == 1, 1'b0);
      else if (pick < 65)
         send_frame(FRAME_LEN, 1'b1, FLAW_NONE, 1'b1, 1'b0);
      else if (pick < 75)
         send_frame($urandom_range(FRAME_LEN + 1, 70), 1'b1, FLAW_NONE, 1'b0, 1'b0);
      else if (pick < 80)
         send_frame(FRAME_LEN, 1'b0, FLAW_NONE, 1'b0, 1'b0);
      else
         send_frame($urandom_range(1, FRAME_LEN - 1), 1'b0, FLAW_NONE, 1'b0, 1'b0);
   endtask

   function automatic cfg_type random_settings();
      cfg_type     s;
      logic [31:0] r;
      r = $urandom();
      s.src_port = r[15:0];
      s.dst_port = r[31:16];
      s.seq      = $urandom();
      s.ack      = $urandom();
      r = $urandom();
      s.flags    = r[7:0];
      return s;
   endfunction

   // Receiver: stall for a random hold before each beat, with calm runs of no stall at all,
   // and one long hold-off when the stimulus asks for it.
   initial begin
      result_type got;
      int         hold;
      int         calm_run;
      calm_run = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (calm_run > 0) begin
            hold = 0;
            calm_run--;
         end else if ($urandom_range(0, 9) == 0) begin
            hold = 0;
            calm_run = $urandom_range(5, 15);
         end else begin
            hold = $urandom_range(0, 3);
         end
         // Long hold: the block fills up and must push back on req
         if (squeeze_req) begin
            hold = 250;
            squeeze_req = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.length_ok      = rsp_length_ok;
         got.header_match   = rsp_header_match;
         got.checksum_good  = rsp_checksum_good;
         got.source_address = rsp_source_address;
         board.check_verdict(got);
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin
      cfg_type plan [0:4];
      int      p;
      int      n;
      board = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames at the reset settings: one- and two-byte frames at the byte
      // extremes, a clean segment, flags and protocol mismatches with correct length,
      // a bad checksum, a frame one byte short and an overlong frame that saturates the index.
      push_byte(8'h00, 1'b1, 0);
      push_byte(8'hFF, 1'b1, 0);
      push_byte(8'hFF, 1'b0, 1);
      push_byte(8'h00, 1'b1, 0);
      send_frame(FRAME_LEN, 1'b1, FLAW_NONE, 1'b0, 1'b1);
      send_frame(FRAME_LEN, 1'b1, FLAW_FLAGS, 1'b0, 1'b0);
      send_frame(FRAME_LEN, 1'b1, FLAW_PROTO, 1'b0, 1'b0);
      send_frame(FRAME_LEN, 1'b1, FLAW_NONE, 1'b1, 1'b0);
      send_frame(FRAME_LEN - 1, 1'b0, FLAW_NONE, 1'b0, 1'b0);
      send_frame(70, 1'b1, FLAW_NONE, 1'b0, 1'b0);

      // Phases: all-zero and all-one extremes, two random settings, then reset values
      plan[0] = '0;
      plan[1] = '1;
      plan[2] = random_settings();
      plan[3] = random_settings();
      plan[4] = '{src_port: RST_SRC_PORT, dst_port: RST_DST_PORT, seq: RST_SEQ,
                  ack: RST_ACK, flags: RST_FLAGS};
      for (p = 0; p < 5; p++) begin
         settle();
         load_settings(plan[p]);
         random_frame();
         if (p == 1) begin
            // Keep offering short frames back to back while the receiver holds off
            squeeze_req = 1'b1;
            for (n = 0; n < 30; n++)
               send_frame($urandom_range(1, 3), 1'b0, FLAW_NONE, 1'b0, 1'b1);
         end
      end

      settle();
      repeat (10) @(negedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[tcp_header_match_checksum_check.f]
sv/tcphm_pkg.sv
sv/tcphm_csr.sv
sv/tcphm_frame.sv
sv/tcp_header_match_checksum_check.sv
tb/testbench.sv
